// ===== rtl/core/utf8d_pkg.sv =====
package utf8d_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CpW     = 21;
  localparam int unsigned PendW   = 2;
  // Output tdata: code point, then the last-of-run flag, padded to whole bytes.
  localparam int unsigned OutDataW = 24;
  localparam int unsigned InDataW  = 8;

  localparam logic [CpW-1:0] ReplResetVal = CpW'(32);

  // One decoded result as it sits in the output queue.
  typedef struct packed {
    logic [CpW-1:0] code_point;
    logic           is_error;
    logic           last_of_run;
    logic           string_done;
  } result_t;

endpackage

// ===== rtl/core/utf8_byte_stream_decoder_unit.sv =====
// UTF-8 byte stream decoder. One raw byte enters per transfer on the slave
// stream (tlast marks the last byte of a string) and decoded code points leave
// on the master stream, one per transfer. A byte can cause zero, one or two
// results; malformed input yields the programmable replacement character with
// tuser set. Decoding is done in the cycle a byte is accepted, and the results
// go into a three-entry output queue, so a byte is taken every cycle as long
// as the queue holds at most one result. The replacement register resets to 32
// and is written through the cfg channel, which is always ready; write it only
// while idle.
module utf8_byte_stream_decoder_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration: replacement code point.
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [utf8d_pkg::CpW-1:0]      cfg_data_i,
  // Byte input.
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [utf8d_pkg::InDataW-1:0]  s_axis_tdata,  // [7:0] data_byte
  input  logic                           s_axis_tlast,  // end_of_string
  // Code point output.
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [utf8d_pkg::OutDataW-1:0] m_axis_tdata,  // [20:0] code_point,
                                                        // [21] last_of_run, [23:22] zero
  output logic                           m_axis_tuser,  // is_error
  output logic                           m_axis_tlast   // string_done
);
  import utf8d_pkg::*;

  localparam int unsigned QDepth = 3;

  logic [CpW-1:0]   repl_q;
  logic [PendW-1:0] pend_q, pend_d;
  logic [CpW-1:0]   part_q, part_d;

  result_t          slot_q [QDepth];
  result_t          slot_d [QDepth];
  logic [1:0]       cnt_q, cnt_d;

  logic             push, pop;
  logic [ByteW-1:0] b;
  logic             eos;
  result_t          r0, r1;
  logic [1:0]       nres;
  logic [1:0]       base;
  result_t          sh [QDepth];

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = ~cnt_q[1];
  assign push          = s_axis_tvalid & s_axis_tready;
  assign pop           = m_axis_tvalid & m_axis_tready;
  assign b             = s_axis_tdata;
  assign eos           = s_axis_tlast;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      repl_q <= ReplResetVal;
    end else if (cfg_valid_i) begin
      repl_q <= cfg_data_i;
    end
  end

  // Byte decode: next decoder state and up to two results.
  always_comb begin
    logic [1:0] k;
    k      = 2'd0;
    pend_d = pend_q;
    part_d = part_q;
    r0     = '0;
    r1     = '0;
    priority if (!b[7]) begin
      if (pend_q != '0) begin
        r0     = '{code_point: repl_q, is_error: 1'b1, default: 1'b0};
        k      = 2'd1;
        pend_d = '0;
      end
      if (k == 2'd0) begin
        r0 = '{code_point: CpW'(b), default: 1'b0};
      end else begin
        r1 = '{code_point: CpW'(b), default: 1'b0};
      end
      k = k + 2'd1;
    end else if (b[7:6] == 2'b10) begin
      if (pend_q != '0) begin
        part_d = {part_q[CpW-7:0], b[5:0]};
        pend_d = pend_q - 2'd1;
        if (pend_d == '0) begin
          r0 = '{code_point: part_d, default: 1'b0};
          k  = 2'd1;
        end
      end else begin
        r0 = '{code_point: repl_q, is_error: 1'b1, default: 1'b0};
        k  = 2'd1;
      end
    end else if (b[7:5] == 3'b110) begin
      pend_d = 2'd1;
      part_d = CpW'(b[4:0]);
    end else if (b[7:4] == 4'b1110) begin
      pend_d = 2'd2;
      part_d = CpW'(b[3:0]);
    end else if (b[7:3] == 5'b11110) begin
      pend_d = 2'd3;
      part_d = CpW'(b[2:0]);
    end else begin
      r0     = '{code_point: repl_q, is_error: 1'b1, default: 1'b0};
      k      = 2'd1;
      pend_d = '0;
    end

    if (eos) begin
      // An unfinished sequence at the end of a string becomes a replacement.
      if (pend_d != '0) begin
        if (k == 2'd0) begin
          r0 = '{code_point: repl_q, is_error: 1'b1, default: 1'b0};
        end else begin
          r1 = '{code_point: repl_q, is_error: 1'b1, default: 1'b0};
        end
        k = k + 2'd1;
      end
      pend_d = '0;
      part_d = '0;
    end

    r0.last_of_run = (k == 2'd1);
    r0.string_done = (k == 2'd1) & eos;
    r1.last_of_run = (k == 2'd2);
    r1.string_done = (k == 2'd2) & eos;
    nres = k;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      part_q <= '0;
    end else if (push) begin
      pend_q <= pend_d;
      part_q <= part_d;
    end
  end

  // Output queue: the head always sits in slot 0; new results land behind
  // whatever remains after this cycle's pop.
  always_comb begin
    sh[0] = pop ? slot_q[1] : slot_q[0];
    sh[1] = pop ? slot_q[2] : slot_q[1];
    sh[2] = slot_q[2];
    base  = cnt_q - {1'b0, pop};
    for (int i = 0; i < QDepth; i++) begin
      slot_d[i] = sh[i];
      if (push && nres != 2'd0 && base == 2'(i)) begin
        slot_d[i] = r0;
      end
      if (push && nres == 2'd2 && base + 2'd1 == 2'(i)) begin
        slot_d[i] = r1;
      end
    end
    cnt_d = push ? base + nres : base;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QDepth; i++) begin
      slot_q[i] <= slot_d[i];
    end
  end

  assign m_axis_tvalid = (cnt_q != '0);
  assign m_axis_tdata  = {(OutDataW-CpW-1)'(0), slot_q[0].last_of_run, slot_q[0].code_point};
  assign m_axis_tuser  = slot_q[0].is_error;
  assign m_axis_tlast  = slot_q[0].string_done;

  // The end of a string always clears the decoder and yields a result.
  a_eos_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && s_axis_tlast |=> pend_q == '0 && part_q == '0)
    else $error("decoder state not cleared after end of string");

  a_eos_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && s_axis_tlast |=> cnt_q != '0)
    else $error("end of string produced no result");

  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[CpW])
    else $error("string_done without last_of_run");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (cnt_q == 2'd0) || (cnt_q == 2'd1))
    else $error("byte accepted with output queue too full");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import utf8d_pkg::*;

  // Byte-class upper bounds.
  localparam logic [7:0] AsciiMax = 8'h7F;
  localparam logic [7:0] ContMax  = 8'hBF;
  localparam logic [7:0] Lead2Max = 8'hDF;
  localparam logic [7:0] Lead3Max = 8'hEF;
  localparam logic [7:0] Lead4Max = 8'hF7;
  localparam logic [CpW-1:0] CpAllOnes = {CpW{1'b1}};
  localparam int DrainSettle = 4;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CpW-1:0]      cfg_data_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;  // [7:0] data_byte
  logic                s_axis_tlast = 1'b0; // end_of_string
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;       // [20:0] code_point, [21] last_of_run
  logic                m_axis_tuser;       // is_error
  logic                m_axis_tlast;       // string_done

  utf8_byte_stream_decoder_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Decoder state as the testbench tracks it.
  logic [PendW-1:0] pend_left = '0;
  logic [CpW-1:0]   cp_accum = '0;
  logic [CpW-1:0]   repl_cp = ReplResetVal;

  result_t    cp_expect_q[$];
  result_t    want;
  logic [7:0] str_q[$];

  int burst_left = 0;
  int bytes_sent = 0;
  int strings_sent = 0;
  int cps_seen = 0;
  int repl_seen = 0;
  int repl_settings = 1;
  int mismatch_count = 0;
  int cyc = 0;

  function automatic void push_cp(input logic [CpW-1:0] cp, input logic err);
    result_t r;
    r = '{code_point: cp, is_error: err, last_of_run: 1'b0, string_done: 1'b0};
    cp_expect_q = {cp_expect_q, r};
  endfunction

  // Works out the code points one accepted byte produces.
  function automatic void decode_byte_model(input logic [7:0] b, input logic eos);
    int      first;
    result_t r;
    first = cp_expect_q.size();
    if (b <= AsciiMax) begin
      if (pend_left != 0) begin
        push_cp(repl_cp, 1'b1);
        pend_left = '0;
      end
      push_cp(CpW'(b), 1'b0);
    end else if (b <= ContMax) begin
      if (pend_left != 0) begin
        cp_accum = {cp_accum[CpW-7:0], b[5:0]};
        pend_left = pend_left - 2'd1;
        if (pend_left == 0) push_cp(cp_accum, 1'b0);
      end else begin
        push_cp(repl_cp, 1'b1);
      end
    end else if (b <= Lead2Max) begin
      pend_left = 2'd1;
      cp_accum = CpW'(b[4:0]);
    end else if (b <= Lead3Max) begin
      pend_left = 2'd2;
      cp_accum = CpW'(b[3:0]);
    end else if (b <= Lead4Max) begin
      pend_left = 2'd3;
      cp_accum = CpW'(b[2:0]);
    end else begin
      push_cp(repl_cp, 1'b1);
      pend_left = '0;
    end
    if (eos) begin
      if (pend_left != 0) push_cp(repl_cp, 1'b1);
      pend_left = '0;
      cp_accum = '0;
    end
    if (cp_expect_q.size() > first) begin
      r = cp_expect_q.pop_back();
      r.last_of_run = 1'b1;
      r.string_done = eos;
      cp_expect_q = {cp_expect_q, r};
    end
  endfunction

  // Result checker plus the receiver's stall pattern. The pattern steps through
  // four phases in turn: always ready, coin flip, sparse, and long stalls.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      cps_seen++;
      if (m_axis_tuser) repl_seen++;
      if (cp_expect_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: unexpected result cp=%h err=%b last=%b done=%b", $realtime,
                   m_axis_tdata[CpW-1:0], m_axis_tuser, m_axis_tdata[CpW], m_axis_tlast);
      end else begin
        want = cp_expect_q.pop_front();
        if (m_axis_tdata[CpW-1:0] !== want.code_point || m_axis_tuser !== want.is_error ||
            m_axis_tdata[CpW] !== want.last_of_run || m_axis_tlast !== want.string_done ||
            m_axis_tdata[OutDataW-1:CpW+1] !== '0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: mismatch exp cp=%h err=%b last=%b done=%b, got tdata=%h err=%b done=%b",
                     $realtime, want.code_point, want.is_error, want.last_of_run,
                     want.string_done, m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end
      end
    end
    cyc++;
    case (cyc[9:8])
      2'd0: m_axis_tready <= 1'b1;
      2'd1: m_axis_tready <= 1'($urandom_range(0, 1));
      2'd2: m_axis_tready <= (cyc[2:0] == 3'd0);
      default: m_axis_tready <= cyc[4];
    endcase
  end

  // Sends one byte; the sender runs in bursts separated by idle gaps.
  task automatic send_byte(input logic [7:0] b, input logic eos);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 12);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tlast <= eos;
    do @(posedge clk_i); while (!s_axis_tready);
    decode_byte_model(b, eos);
    bytes_sent++;
    if (eos) strings_sent++;
  endtask

  // Holds the input off until every pending code point has come out.
  task automatic wait_drain;
    s_axis_tvalid <= 1'b0;
    while (cp_expect_q.size() != 0) @(posedge clk_i);
    repeat (DrainSettle) @(posedge clk_i);
    burst_left = 0;
  endtask

  task automatic write_replacement(input logic [CpW-1:0] cp);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= cp;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    repl_cp = cp;
    repl_settings++;
  endtask

  // Appends one character to the string being built: mostly well-formed
  // sequences with random payload, some cut short, some raw noise.
  function automatic void add_char;
    int k;
    int extra;
    int keep;
    k = $urandom_range(0, 99);
    if (k < 25) begin
      str_q = {str_q, 8'($urandom_range(0, 127))};
    end else if (k < 85) begin
      extra = $urandom_range(1, 3);
      keep = (k >= 75) ? $urandom_range(0, extra - 1) : extra;
      case (extra)
        1: str_q = {str_q, {3'b110, 5'($urandom)}};
        2: str_q = {str_q, {4'b1110, 4'($urandom)}};
        default: str_q = {str_q, {5'b11110, 3'($urandom)}};
      endcase
      for (int i = 0; i < keep; i++) str_q = {str_q, {2'b10, 6'($urandom)}};
    end else if (k < 95) begin
      str_q = {str_q, 8'($urandom_range(0, 255))};
    end else begin
      str_q = {str_q, 8'($urandom_range(8'hF8, 8'hFF))};
    end
  endfunction

  task automatic send_random_strings(input int n_bytes);
    int target;
    int n_chars;
    target = bytes_sent + n_bytes;
    while (bytes_sent < target) begin
      str_q.delete();
      n_chars = $urandom_range(1, 6);
      for (int i = 0; i < n_chars; i++) add_char();
      for (int i = 0; i < str_q.size(); i++) send_byte(str_q[i], i == str_q.size() - 1);
    end
  endtask

  task automatic test_ascii_bytes;
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b1);
  endtask

  task automatic test_multibyte_sequences;
    send_byte(8'hC2, 1'b0);
    send_byte(8'hA9, 1'b0);
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b0);
    send_byte(8'hAC, 1'b0);
    // Largest value a four-byte lead can reach.
    send_byte(8'hF7, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b1);
  endtask

  task automatic test_malformed_input;
    send_byte(8'h80, 1'b0);  // stray continuation
    send_byte(8'hF8, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hE2, 1'b0);  // ASCII interrupts a sequence
    send_byte(8'h41, 1'b0);
    send_byte(8'hE2, 1'b0);  // new lead drops the old sequence
    send_byte(8'hC3, 1'b0);
    send_byte(8'hA9, 1'b0);
    send_byte(8'hF0, 1'b0);  // string ends mid-sequence
    send_byte(8'h9F, 1'b1);
    send_byte(8'hBF, 1'b1);
    send_byte(8'hE0, 1'b1);  // string ends right on a lead
  endtask

  task automatic test_replacement_extremes;
    logic [CpW-1:0] settings[4];
    settings[0] = CpAllOnes;
    settings[1] = '0;
    settings[2] = CpW'($urandom_range(0, CpAllOnes));
    settings[3] = ReplResetVal;
    foreach (settings[i]) begin
      wait_drain();
      write_replacement(settings[i]);
      send_random_strings(40);
    end
  endtask

  task automatic test_random_strings;
    for (int i = 0; i < 4; i++) begin
      send_random_strings(85);
      wait_drain();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_ascii_bytes();
    test_multibyte_sequences();
    test_malformed_input();
    test_replacement_extremes();
    test_random_strings();
    wait_drain();
    repeat (8) @(posedge clk_i);
    if (cp_expect_q.size() != 0) mismatch_count++;
    $display("Covered %0d bytes in %0d strings under %0d replacement settings;",
             bytes_sent, strings_sent, repl_settings);
    $display("checked %0d code points, %0d of them replacements.", cps_seen, repl_seen);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/utf8d_pkg.sv
rtl/core/utf8_byte_stream_decoder_unit.sv
verif/tb.sv
